>>> design/source_text_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STT_ASSERT_SAME(lbl, ante, cons, msg)
`define STT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/stt_pkg.sv
// Types and constants of the source text tokenizer.
package stt_pkg;

    localparam int LINE_OUT_W = 20;
    localparam int COL_OUT_W  = 16;
    localparam int OFF_OUT_W  = 24;
    localparam int LEN_W      = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;
    localparam int KW_NUM     = 4;
    localparam int KW_MAX_LEN = 8;

    typedef enum logic [2:0] {
        TK_KEYWORD = 3'd0,
        TK_IDENT   = 3'd1,
        TK_INTEGER = 3'd2,
        TK_FLOAT   = 3'd3,
        TK_OPER    = 3'd4,
        TK_PUNCT   = 3'd5,
        TK_UNKNOWN = 3'd6,
        TK_EOF     = 3'd7
    } tok_kind_t;

    // Kind of the token still being collected.
    typedef enum logic [3:0] {
        PK_NONE  = 4'b0001,
        PK_WORD  = 4'b0010,
        PK_INT   = 4'b0100,
        PK_FLOAT = 4'b1000
    } pend_kind_t;

    typedef struct packed {
        tok_kind_t              kind;
        logic [LINE_OUT_W-1:0]  line;
        logic [COL_OUT_W-1:0]   col;
        logic [OFF_OUT_W-1:0]   off;
        logic [LEN_W-1:0]       len;
    } tok_rec_t;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Keywords: int, float, char, string (padded with zero).
    localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{16'd3, 16'd5, 16'd4, 16'd6};

endpackage

>>> design/source_text_tokenizer_top.sv
// Streaming tokenizer: one source byte in per word, tokens out per word.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  source  | src_valid/src_stall | mode, char_byte
//  token   | tok_valid/tok_stall | token_kind, start_line, start_column,
//          |                     | start_offset, token_length, last_of_run
//
// A byte waits in the input register until the result register can take its
// tokens, which are then registered there. One byte is taken per cycle while
// each byte gives at most one token and tok_stall is low; a byte giving two
// tokens holds the input register while both drain from the result register.
// Reset clears position counters to line 1, column 1, offset 0 and drops
// any pending token. tok_stall holds the result; src_stall rises only when
// the input register is full and the result register cannot drain.
`include "source_text_tokenizer_top_defines.svh"

module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16,
    parameter int OFFSET_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  logic                  mode,
    input  logic [7:0]            char_byte,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output logic [2:0]            token_kind,
    output logic [LINE_OUT_W-1:0] start_line,
    output logic [COL_OUT_W-1:0]  start_column,
    output logic [OFF_OUT_W-1:0]  start_offset,
    output logic [LEN_W-1:0]      token_length,
    output logic                  last_of_run
);

    localparam int LINE_W = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;
    localparam int COL_W  = (COLUMN_BITS > COL_OUT_W) ? COLUMN_BITS : COL_OUT_W;
    localparam int OFF_W  = (OFFSET_BITS > OFF_OUT_W) ? OFFSET_BITS : OFF_OUT_W;

    // input register
    logic                   src_valid_reg;
    logic                   mode_reg;
    logic [7:0]             byte_reg;

    // pending token and position state
    pend_kind_t             pend_kind_reg,  pend_kind_next;
    logic [LINE_BITS-1:0]   pend_line_reg,  pend_line_next;
    logic [COLUMN_BITS-1:0] pend_col_reg,   pend_col_next;
    logic [OFFSET_BITS-1:0] pend_off_reg,   pend_off_next;
    logic [LEN_W-1:0]       pend_len_reg,   pend_len_next;
    logic [KW_NUM-1:0]      cand_reg,       cand_next;
    logic [LINE_BITS-1:0]   cur_line_reg,   cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg,    cur_col_next;
    logic [OFFSET_BITS-1:0] cur_off_reg,    cur_off_next;

    // result register: flushed pending token, then the byte's own token
    tok_rec_t               flush_rec_reg;
    tok_rec_t               own_rec_reg;
    logic                   has_flush_reg;
    logic                   has_own_reg;

    logic                   out_last;
    logic                   out_done;
    logic                   process;
    logic                   take;

    logic                   is_alpha, is_digit, is_space, is_oper, is_punct, is_dot;
    logic                   has_pend, extend;
    logic                   emit_flush, emit_own;
    tok_kind_t              own_kind, flush_kind;
    logic [LEN_W-1:0]       own_len;
    logic [LEN_W-1:0]       len_inc;
    logic                   kw_hit;
    tok_rec_t               flush_rec, own_rec;

    logic [LINE_W-1:0]      pend_line_wide, cur_line_wide;
    logic [COL_W-1:0]       pend_col_wide,  cur_col_wide;
    logic [OFF_W-1:0]       pend_off_wide,  cur_off_wide;

    function automatic logic [KW_NUM-1:0] narrow(input logic [KW_NUM-1:0] cand,
                                                 input logic [LEN_W-1:0]  idx,
                                                 input logic [7:0]        b);
        logic [KW_NUM-1:0] res;
        res = cand;
        for (int i = 0; i < KW_NUM; i++)
        begin
            if (!((idx < KW_LEN[i]) && (KW_TEXT[i][idx[2:0]] == b)))
            begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    // handshake
    assign tok_valid = has_flush_reg || has_own_reg;
    assign out_last  = has_flush_reg ? !has_own_reg : 1'b1;
    assign out_done  = tok_valid && !tok_stall && out_last;
    assign process   = src_valid_reg && (!tok_valid || out_done);
    assign src_stall = src_valid_reg && !process;
    assign take      = src_valid && !src_stall;

    always_comb
    begin
        if (has_flush_reg)
        begin
            token_kind   = flush_rec_reg.kind;
            start_line   = flush_rec_reg.line;
            start_column = flush_rec_reg.col;
            start_offset = flush_rec_reg.off;
            token_length = flush_rec_reg.len;
        end
        else
        begin
            token_kind   = own_rec_reg.kind;
            start_line   = own_rec_reg.line;
            start_column = own_rec_reg.col;
            start_offset = own_rec_reg.off;
            token_length = own_rec_reg.len;
        end
    end
    assign last_of_run = out_last;

    // byte classes
    assign is_alpha = ((byte_reg >= 8'h61) && (byte_reg <= 8'h7A)) ||
                      ((byte_reg >= 8'h41) && (byte_reg <= 8'h5A)) ||
                      (byte_reg == CH_UNDER);
    assign is_digit = (byte_reg >= 8'h30) && (byte_reg <= 8'h39);
    assign is_space = (byte_reg == CH_SPACE) || (byte_reg == CH_TAB) ||
                      (byte_reg == CH_LF) || (byte_reg == CH_VT) ||
                      (byte_reg == CH_FF) || (byte_reg == CH_CR);
    assign is_oper  = (byte_reg == CH_PLUS) || (byte_reg == CH_MINUS) ||
                      (byte_reg == CH_STAR) || (byte_reg == CH_SLASH) ||
                      (byte_reg == CH_EQUAL);
    assign is_punct = (byte_reg == CH_SEMI) || (byte_reg == CH_COMMA) ||
                      (byte_reg == CH_LPAREN) || (byte_reg == CH_RPAREN) ||
                      (byte_reg == CH_LBRACE) || (byte_reg == CH_RBRACE);
    assign is_dot   = (byte_reg == CH_DOT);

    assign has_pend = (pend_kind_reg != PK_NONE);
    assign extend   = ((pend_kind_reg == PK_WORD) && (is_alpha || is_digit)) ||
                      (((pend_kind_reg == PK_INT) || (pend_kind_reg == PK_FLOAT)) &&
                       is_digit) ||
                      ((pend_kind_reg == PK_INT) && is_dot);
    assign len_inc  = (pend_len_reg == LEN_MAX) ? LEN_MAX : pend_len_reg + LEN_W'(1);

    always_comb
    begin
        kw_hit = 1'b0;
        for (int i = 0; i < KW_NUM; i++)
        begin
            if (cand_reg[i] && (pend_len_reg == KW_LEN[i]))
            begin
                kw_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (pend_kind_reg)
            PK_WORD:  flush_kind = kw_hit ? TK_KEYWORD : TK_IDENT;
            PK_INT:   flush_kind = TK_INTEGER;
            PK_FLOAT: flush_kind = TK_FLOAT;
            default:  flush_kind = TK_IDENT;
        endcase
    end

    // fold parameter-width counters onto the fixed result widths
    assign pend_line_wide = LINE_W'(pend_line_reg);
    assign pend_col_wide  = COL_W'(pend_col_reg);
    assign pend_off_wide  = OFF_W'(pend_off_reg);
    assign cur_line_wide  = LINE_W'(cur_line_reg);
    assign cur_col_wide   = COL_W'(cur_col_reg);
    assign cur_off_wide   = OFF_W'(cur_off_reg);

    assign flush_rec.kind = flush_kind;
    assign flush_rec.line = pend_line_wide[LINE_OUT_W-1:0];
    assign flush_rec.col  = pend_col_wide[COL_OUT_W-1:0];
    assign flush_rec.off  = pend_off_wide[OFF_OUT_W-1:0];
    assign flush_rec.len  = pend_len_reg;
    assign own_rec.kind   = own_kind;
    assign own_rec.line   = cur_line_wide[LINE_OUT_W-1:0];
    assign own_rec.col    = cur_col_wide[COL_OUT_W-1:0];
    assign own_rec.off    = cur_off_wide[OFF_OUT_W-1:0];
    assign own_rec.len    = own_len;

    always_comb
    begin
        pend_kind_next = pend_kind_reg;
        pend_line_next = pend_line_reg;
        pend_col_next  = pend_col_reg;
        pend_off_next  = pend_off_reg;
        pend_len_next  = pend_len_reg;
        cand_next      = cand_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        cur_off_next   = cur_off_reg;
        emit_flush     = 1'b0;
        emit_own       = 1'b0;
        own_kind       = TK_UNKNOWN;
        own_len        = LEN_W'(1);
        if (process)
        begin
            if (mode_reg)
            begin
                // end of text: flush, then end-of-file token; keep position
                emit_flush     = has_pend;
                emit_own       = 1'b1;
                own_kind       = TK_EOF;
                own_len        = '0;
                pend_kind_next = PK_NONE;
                pend_len_next  = '0;
                cand_next      = '1;
            end
            else
            begin
                if (extend)
                begin
                    if (pend_kind_reg == PK_INT && is_dot)
                    begin
                        pend_kind_next = PK_FLOAT;
                    end
                    if (pend_kind_reg == PK_WORD)
                    begin
                        cand_next = narrow(cand_reg, pend_len_reg, byte_reg);
                    end
                    pend_len_next = len_inc;
                end
                else
                begin
                    emit_flush     = has_pend;
                    pend_kind_next = PK_NONE;
                    pend_len_next  = '0;
                    cand_next      = '1;
                    priority if (is_space)
                    begin
                        pend_kind_next = PK_NONE;
                    end
                    else if (is_alpha || is_digit)
                    begin
                        // open a new word or number at the current position
                        pend_kind_next = is_alpha ? PK_WORD : PK_INT;
                        pend_line_next = cur_line_reg;
                        pend_col_next  = cur_col_reg;
                        pend_off_next  = cur_off_reg;
                        pend_len_next  = LEN_W'(1);
                        if (is_alpha)
                        begin
                            cand_next = narrow('1, '0, byte_reg);
                        end
                    end
                    else
                    begin
                        emit_own = 1'b1;
                        own_kind = is_oper ? TK_OPER : (is_punct ? TK_PUNCT : TK_UNKNOWN);
                    end
                end
                // advance position, saturating
                if (byte_reg == CH_LF)
                begin
                    if (cur_line_reg != {LINE_BITS{1'b1}})
                    begin
                        cur_line_next = cur_line_reg + LINE_BITS'(1);
                    end
                    cur_col_next = COLUMN_BITS'(1);
                end
                else if (cur_col_reg != {COLUMN_BITS{1'b1}})
                begin
                    cur_col_next = cur_col_reg + COLUMN_BITS'(1);
                end
                if (cur_off_reg != {OFFSET_BITS{1'b1}})
                begin
                    cur_off_next = cur_off_reg + OFFSET_BITS'(1);
                end
            end
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg <= 1'b0;
            pend_kind_reg <= PK_NONE;
            pend_line_reg <= LINE_BITS'(1);
            pend_col_reg  <= COLUMN_BITS'(1);
            pend_off_reg  <= '0;
            pend_len_reg  <= '0;
            cand_reg      <= '1;
            cur_line_reg  <= LINE_BITS'(1);
            cur_col_reg   <= COLUMN_BITS'(1);
            cur_off_reg   <= '0;
            has_flush_reg <= 1'b0;
            has_own_reg   <= 1'b0;
        end
        else
        begin
            src_valid_reg <= take || (src_valid_reg && !process);
            pend_kind_reg <= pend_kind_next;
            pend_line_reg <= pend_line_next;
            pend_col_reg  <= pend_col_next;
            pend_off_reg  <= pend_off_next;
            pend_len_reg  <= pend_len_next;
            cand_reg      <= cand_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            cur_off_reg   <= cur_off_next;
            if (process)
            begin
                has_flush_reg <= emit_flush;
                has_own_reg   <= emit_own;
            end
            else if (tok_valid && !tok_stall)
            begin
                // drop the word just taken
                if (has_flush_reg)
                begin
                    has_flush_reg <= 1'b0;
                end
                else
                begin
                    has_own_reg <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg <= mode;
            byte_reg <= char_byte;
        end
        if (process)
        begin
            flush_rec_reg <= flush_rec;
            own_rec_reg   <= own_rec;
        end
    end

    `STT_ASSERT_SAME(a_flush_kind, has_flush_reg, flush_rec_reg.kind == TK_KEYWORD || flush_rec_reg.kind == TK_IDENT || flush_rec_reg.kind == TK_INTEGER || flush_rec_reg.kind == TK_FLOAT, "flushed token has a non-pending kind")
    `STT_ASSERT_SAME(a_eof_len, has_own_reg && own_rec_reg.kind == TK_EOF, own_rec_reg.len == '0, "end-of-file token with nonzero length")
    `STT_ASSERT_SAME(a_pend_len, pend_kind_reg != PK_NONE, pend_len_reg != '0, "pending token with zero length")
    `STT_ASSERT_NEXT(a_hold_input, src_valid_reg && !process, src_valid_reg, "input byte lost while held")

endmodule
